@@ sv/atag_pkg.sv @@
package atag_pkg;

  // Input action codes
  localparam logic ACT_BEGIN   = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  // Configuration register indices
  localparam logic [1:0] CFG_DEST_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_DEST_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_TEX_WIDTH   = 2'd2;
  localparam logic [1:0] CFG_TEX_HEIGHT  = 2'd3;

  // Fixed field widths
  localparam int COORD_W   = 32;            // corners and accumulators
  localparam int DVD_W     = COORD_W + 1;   // exact corner difference
  localparam int DSR_W     = 26;            // 13 x 13 bit texture area
  localparam int DDIM_REG_W = 11;
  localparam int TDIM_REG_W = 13;
  localparam int CFG_DATA_W = 13;
  localparam int POS_W     = 10;            // dest_x / dest_y ports
  localparam int TEX_W     = 9;             // tex_col / tex_row ports

  // Register reset values
  localparam logic [DDIM_REG_W-1:0] DEST_WIDTH_RST  = 11'd320;
  localparam logic [DDIM_REG_W-1:0] DEST_HEIGHT_RST = 11'd240;
  localparam logic [TDIM_REG_W-1:0] TEX_WIDTH_RST   = 13'd512;
  localparam logic [TDIM_REG_W-1:0] TEX_HEIGHT_RST  = 13'd512;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_OUT
  } state_t;

  // Divisions run by the shared divider, in sequence order
  typedef enum logic [2:0] {
    OP_SXP,   // step x per pixel
    OP_SYP,   // step y per pixel
    OP_SXR,   // step x per row
    OP_SYR,   // step y per row
    OP_TCOL,  // texture column from y accumulator
    OP_TROW   // texture row from x accumulator
  } op_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;  // two's complement
    logic [DSR_W-1:0] divisor;   // unsigned, non-zero
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [COORD_W-1:0] quotient;  // low bits, truncated toward zero
  } div_rsp_t;

endpackage

@@ sv/atag_div.sv @@
// Signed by unsigned restoring divider: a sign-strip step, then one
// quotient bit per cycle. Quotient truncated toward zero.
module atag_div (
  input  logic                clk,
  input  logic                rst_n,
  input  atag_pkg::div_req_t  req,
  output atag_pkg::div_rsp_t  rsp
);

  localparam int QW  = atag_pkg::COORD_W;
  localparam int DW  = atag_pkg::DSR_W;
  localparam int CW  = $clog2(QW);

  logic                     busy_r, prep_r, done_r;
  logic [CW-1:0]            cnt_r;
  logic [atag_pkg::DVD_W-1:0] dvd_r;
  logic [DW-1:0]            dsr_r, rem_r;
  logic [QW-1:0]            quo_r;
  logic                     neg_r;

  logic [atag_pkg::DVD_W-1:0] mag;
  logic [DW:0]              trial, diff;
  logic                     ge;

  always_comb begin
    mag   = dvd_r[atag_pkg::DVD_W-1] ? (atag_pkg::DVD_W'(0) - dvd_r) : dvd_r;
    trial = {rem_r, quo_r[QW-1]};
    diff  = trial - {1'b0, dsr_r};
    ge    = (trial >= {1'b0, dsr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      prep_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        prep_r <= 1'b1;
      end else if (prep_r) begin
        prep_r <= 1'b0;
      end else if (busy_r && (cnt_r == CW'(QW - 1))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
    end else if (prep_r) begin
      // |difference| never exceeds 2^32-1
      quo_r <= mag[QW-1:0];
      neg_r <= dvd_r[atag_pkg::DVD_W-1];
      rem_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_r <= {quo_r[QW-2:0], ge};
      cnt_r <= cnt_r + CW'(1);
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? (QW'(0) - quo_r) : quo_r;

endmodule

@@ sv/affine_texture_address_generator.sv @@
// Affine texture address generator. A begin-frame transaction (action 0)
// carries corners A (top-left), B (top-right) and C (bottom-left); the block
// derives per-pixel steps (B-A)/width and per-row steps (C-A)/height,
// truncated toward zero, and restarts the raster walk at A. Each advance
// transaction (action 1) while a frame is active returns one result: the
// destination x/y, texture column = trunc(acc_y/(tex_w*tex_h)) and texture
// row = trunc(acc_x/(tex_w*tex_h)), both masked, and frame_last on the final
// pixel. Advances with no frame active are taken and dropped. All divisions
// go through one shared iterative divider (a sign step plus 32 bit
// steps), and the block handles a single transaction at a time: in_stall is
// high from acceptance until the block is back in idle. A begin frame runs
// four divisions; an advance runs two and then holds the result on the
// output until it is taken. Zero dimension registers act as 1; destination
// dimensions above MAX_DEST_DIM act as MAX_DEST_DIM. Configuration writes
// are always ready and must only be made while idle.
module affine_texture_address_generator #(
  parameter int MAX_DEST_DIM  = 1024,
  parameter int TEX_MASK_BITS = 9
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input transactions
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_action,
  input  logic signed [atag_pkg::COORD_W-1:0] in_corner_a_x,
  input  logic signed [atag_pkg::COORD_W-1:0] in_corner_a_y,
  input  logic signed [atag_pkg::COORD_W-1:0] in_corner_b_x,
  input  logic signed [atag_pkg::COORD_W-1:0] in_corner_b_y,
  input  logic signed [atag_pkg::COORD_W-1:0] in_corner_c_x,
  input  logic signed [atag_pkg::COORD_W-1:0] in_corner_c_y,
  // result transactions
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [atag_pkg::POS_W-1:0]          out_dest_x,
  output logic [atag_pkg::POS_W-1:0]          out_dest_y,
  output logic [atag_pkg::TEX_W-1:0]          out_tex_col,
  output logic [atag_pkg::TEX_W-1:0]          out_tex_row,
  output logic                                out_frame_last,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [atag_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CW       = atag_pkg::COORD_W;
  localparam int CNT_W    = $clog2(MAX_DEST_DIM);      // counts 0..MAX-1
  localparam int DIM_W    = $clog2(MAX_DEST_DIM + 1);  // holds MAX itself
  localparam int TEX_KEEP = (TEX_MASK_BITS < atag_pkg::TEX_W) ?
                            TEX_MASK_BITS : atag_pkg::TEX_W;
  localparam logic [atag_pkg::TEX_W-1:0] TEX_MASK =
                            atag_pkg::TEX_W'((1 << TEX_KEEP) - 1);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [atag_pkg::DDIM_REG_W-1:0] dest_width_r, dest_height_r;
  logic [atag_pkg::TDIM_REG_W-1:0] tex_width_r, tex_height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_width_r  <= atag_pkg::DEST_WIDTH_RST;
      dest_height_r <= atag_pkg::DEST_HEIGHT_RST;
      tex_width_r   <= atag_pkg::TEX_WIDTH_RST;
      tex_height_r  <= atag_pkg::TEX_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        atag_pkg::CFG_DEST_WIDTH:  dest_width_r  <= cfg_data[atag_pkg::DDIM_REG_W-1:0];
        atag_pkg::CFG_DEST_HEIGHT: dest_height_r <= cfg_data[atag_pkg::DDIM_REG_W-1:0];
        atag_pkg::CFG_TEX_WIDTH:   tex_width_r   <= cfg_data;
        atag_pkg::CFG_TEX_HEIGHT:  tex_height_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective dimensions: zero acts as 1, destination clamped to MAX
  logic [DIM_W-1:0]                 dim_w, dim_h;
  logic [atag_pkg::TDIM_REG_W-1:0]  tw, th;
  logic [atag_pkg::DSR_W-1:0]       area;

  always_comb begin
    if (dest_width_r == '0) begin
      dim_w = DIM_W'(1);
    end else if (32'(dest_width_r) > 32'(MAX_DEST_DIM)) begin
      dim_w = DIM_W'(MAX_DEST_DIM);
    end else begin
      dim_w = DIM_W'(dest_width_r);
    end
    if (dest_height_r == '0) begin
      dim_h = DIM_W'(1);
    end else if (32'(dest_height_r) > 32'(MAX_DEST_DIM)) begin
      dim_h = DIM_W'(MAX_DEST_DIM);
    end else begin
      dim_h = DIM_W'(dest_height_r);
    end
    tw   = (tex_width_r  == '0) ? atag_pkg::TDIM_REG_W'(1) : tex_width_r;
    th   = (tex_height_r == '0) ? atag_pkg::TDIM_REG_W'(1) : tex_height_r;
    area = atag_pkg::DSR_W'(tw) * atag_pkg::DSR_W'(th);
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  atag_pkg::state_t state_r, state_nxt;
  atag_pkg::op_t    op_r;
  atag_pkg::div_req_t div_req;
  atag_pkg::div_rsp_t div_rsp;

  logic frame_active_r;
  logic in_acc;
  logic div_start;

  assign in_acc = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      atag_pkg::ST_IDLE: begin
        if (in_acc && ((in_action == atag_pkg::ACT_BEGIN) || frame_active_r)) begin
          state_nxt = atag_pkg::ST_ISSUE;
        end
      end
      atag_pkg::ST_ISSUE: state_nxt = atag_pkg::ST_WAIT;
      atag_pkg::ST_WAIT: begin
        if (div_rsp.done) begin
          if (op_r == atag_pkg::OP_SYR) begin
            state_nxt = atag_pkg::ST_IDLE;
          end else if (op_r == atag_pkg::OP_TROW) begin
            state_nxt = atag_pkg::ST_OUT;
          end else begin
            state_nxt = atag_pkg::ST_ISSUE;
          end
        end
      end
      atag_pkg::ST_OUT: begin
        if (!out_stall) begin
          state_nxt = atag_pkg::ST_IDLE;
        end
      end
      default: state_nxt = atag_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != atag_pkg::ST_IDLE);
    out_valid = (state_r == atag_pkg::ST_OUT);
    div_start = (state_r == atag_pkg::ST_ISSUE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= atag_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next operation in the chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= atag_pkg::OP_SXP;
    end else if (in_acc) begin
      op_r <= (in_action == atag_pkg::ACT_BEGIN) ? atag_pkg::OP_SXP : atag_pkg::OP_TCOL;
    end else if ((state_r == atag_pkg::ST_WAIT) && div_rsp.done) begin
      case (op_r)
        atag_pkg::OP_SXP:  op_r <= atag_pkg::OP_SYP;
        atag_pkg::OP_SYP:  op_r <= atag_pkg::OP_SXR;
        atag_pkg::OP_SXR:  op_r <= atag_pkg::OP_SYR;
        atag_pkg::OP_TCOL: op_r <= atag_pkg::OP_TROW;
        default:           op_r <= op_r;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Walk state
  // ---------------------------------------------------------------------
  logic [CW-1:0] row_start_x_r, row_start_y_r, pixel_acc_x_r, pixel_acc_y_r;
  logic [CW-1:0] step_x_pix_r, step_y_pix_r, step_x_row_r, step_y_row_r;
  logic [CW-1:0] corner_b_x_r, corner_b_y_r, corner_c_x_r, corner_c_y_r;
  logic [CNT_W-1:0] col_count_r, row_count_r;

  logic [atag_pkg::POS_W-1:0] dest_x_r, dest_y_r;
  logic [atag_pkg::TEX_W-1:0] tex_col_r, tex_row_r;
  logic                       frame_last_r;

  logic [DIM_W-1:0] col_inc, row_inc;
  logic             row_end, frame_end, pix_done;

  assign col_inc   = DIM_W'(col_count_r) + DIM_W'(1);
  assign row_inc   = DIM_W'(row_count_r) + DIM_W'(1);
  assign row_end   = (col_inc >= dim_w);
  assign frame_end = row_end && (row_inc >= dim_h);
  assign pix_done  = (state_r == atag_pkg::ST_WAIT) && div_rsp.done &&
                     (op_r == atag_pkg::OP_TROW);

  // divider request: start pulse, corner difference against A (held in row start)
  always_comb begin
    div_req.start = div_start;
    case (op_r)
      atag_pkg::OP_SXP: begin
        div_req.dividend = {corner_b_x_r[CW-1], corner_b_x_r} -
                           {row_start_x_r[CW-1], row_start_x_r};
        div_req.divisor  = atag_pkg::DSR_W'(dim_w);
      end
      atag_pkg::OP_SYP: begin
        div_req.dividend = {corner_b_y_r[CW-1], corner_b_y_r} -
                           {row_start_y_r[CW-1], row_start_y_r};
        div_req.divisor  = atag_pkg::DSR_W'(dim_w);
      end
      atag_pkg::OP_SXR: begin
        div_req.dividend = {corner_c_x_r[CW-1], corner_c_x_r} -
                           {row_start_x_r[CW-1], row_start_x_r};
        div_req.divisor  = atag_pkg::DSR_W'(dim_h);
      end
      atag_pkg::OP_SYR: begin
        div_req.dividend = {corner_c_y_r[CW-1], corner_c_y_r} -
                           {row_start_y_r[CW-1], row_start_y_r};
        div_req.divisor  = atag_pkg::DSR_W'(dim_h);
      end
      atag_pkg::OP_TCOL: begin
        div_req.dividend = {pixel_acc_y_r[CW-1], pixel_acc_y_r};
        div_req.divisor  = area;
      end
      atag_pkg::OP_TROW: begin
        div_req.dividend = {pixel_acc_x_r[CW-1], pixel_acc_x_r};
        div_req.divisor  = area;
      end
      default: begin
        div_req.dividend = '0;
        div_req.divisor  = atag_pkg::DSR_W'(1);
      end
    endcase
  end

  atag_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_active_r <= 1'b0;
    end else if (in_acc && (in_action == atag_pkg::ACT_BEGIN)) begin
      frame_active_r <= 1'b1;
    end else if (pix_done && frame_end) begin
      frame_active_r <= 1'b0;
    end
  end

  // counters, accumulators and steps (all cleared by reset; counters return to zero at frame end)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_start_x_r <= '0;
      row_start_y_r <= '0;
      pixel_acc_x_r <= '0;
      pixel_acc_y_r <= '0;
      step_x_pix_r  <= '0;
      step_y_pix_r  <= '0;
      step_x_row_r  <= '0;
      step_y_row_r  <= '0;
      col_count_r   <= '0;
      row_count_r   <= '0;
    end else if (in_acc && (in_action == atag_pkg::ACT_BEGIN)) begin
      row_start_x_r <= in_corner_a_x;
      row_start_y_r <= in_corner_a_y;
      pixel_acc_x_r <= in_corner_a_x;
      pixel_acc_y_r <= in_corner_a_y;
      col_count_r   <= '0;
      row_count_r   <= '0;
    end else if ((state_r == atag_pkg::ST_WAIT) && div_rsp.done) begin
      case (op_r)
        atag_pkg::OP_SXP: step_x_pix_r <= div_rsp.quotient;
        atag_pkg::OP_SYP: step_y_pix_r <= div_rsp.quotient;
        atag_pkg::OP_SXR: step_x_row_r <= div_rsp.quotient;
        atag_pkg::OP_SYR: step_y_row_r <= div_rsp.quotient;
        atag_pkg::OP_TROW: begin
          if (row_end) begin
            // next row restarts from the advanced row start
            row_start_x_r <= row_start_x_r + step_x_row_r;
            row_start_y_r <= row_start_y_r + step_y_row_r;
            pixel_acc_x_r <= row_start_x_r + step_x_row_r;
            pixel_acc_y_r <= row_start_y_r + step_y_row_r;
            col_count_r   <= '0;
            row_count_r   <= frame_end ? '0 : CNT_W'(row_inc);
          end else begin
            pixel_acc_x_r <= pixel_acc_x_r + step_x_pix_r;
            pixel_acc_y_r <= pixel_acc_y_r + step_y_pix_r;
            col_count_r   <= CNT_W'(col_inc);
          end
        end
        default: ;
      endcase
    end
  end

  // corners B and C held for the step divisions
  always_ff @(posedge clk) begin
    if (in_acc && (in_action == atag_pkg::ACT_BEGIN)) begin
      corner_b_x_r <= in_corner_b_x;
      corner_b_y_r <= in_corner_b_y;
      corner_c_x_r <= in_corner_c_x;
      corner_c_y_r <= in_corner_c_y;
    end
  end

  // result register, held while the result is stalled
  always_ff @(posedge clk) begin
    if ((state_r == atag_pkg::ST_WAIT) && div_rsp.done && (op_r == atag_pkg::OP_TCOL)) begin
      tex_col_r <= div_rsp.quotient[atag_pkg::TEX_W-1:0] & TEX_MASK;
    end
    if (pix_done) begin
      tex_row_r    <= div_rsp.quotient[atag_pkg::TEX_W-1:0] & TEX_MASK;
      dest_x_r     <= atag_pkg::POS_W'(col_count_r);
      dest_y_r     <= atag_pkg::POS_W'(row_count_r);
      frame_last_r <= frame_end;
    end
  end

  assign out_dest_x     = dest_x_r;
  assign out_dest_y     = dest_y_r;
  assign out_tex_col    = tex_col_r;
  assign out_tex_row    = tex_row_r;
  assign out_frame_last = frame_last_r;

endmodule

@@ sv/atag_chk.sv @@
module atag_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic in_action,
  input logic out_valid,
  input logic out_stall
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // no new transaction taken while a result waits
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  // an accepted begin frame keeps the block busy with no result offered
  a_begin_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_action == atag_pkg::ACT_BEGIN) |=> in_stall && !out_valid)
    else $error("begin frame not processed");

  // one result per transaction
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid)
    else $error("result repeated");

endmodule

bind affine_texture_address_generator atag_chk u_atag_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_action (in_action),
  .out_valid (out_valid),
  .out_stall (out_stall)
);
